// ===== hdl/fird_pkg.sv =====
// ----------------------------------------------------------------------------
// fird_pkg
// Shared constants, codes and control types of the decimating fir filter.
// ----------------------------------------------------------------------------
package fird_pkg;

  // sizing
  localparam int MAX_TAPS       = 64;
  localparam int MAX_DECIMATION = 16;

  localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int PHASE_W = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int DECIM_W = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION + 1) : 1;

  // fixed widths of the word fields and registers
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int CIDX_W     = 6;
  localparam int DECREG_W   = 5;
  localparam int TAPSREG_W  = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // arithmetic
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int FRAC   = 15;

  // register reset values
  localparam logic [DECREG_W-1:0]  DECIM_RESET = DECREG_W'(2);
  localparam logic [TAPSREG_W-1:0] TAPS_RESET  = TAPSREG_W'(64);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS   = 1'b1;

  // input word commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;   // input word accepted
    logic start;  // clear accumulator, load tap walk
    logic issue;  // read one tap pair
    logic load;   // move result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fire;      // offered word is a sample that completes a phase
    logic tap_last;  // tap walk at its final entry
    logic busy;      // multiply-accumulate pipe still holds data
    logic out_free;  // output register can take a result
  } dp_status_t;

endpackage

// ===== hdl/fird_in_if.sv =====
// ----------------------------------------------------------------------------
// fird_in_if
// Input channel: sample pushes and coefficient loads.
// ----------------------------------------------------------------------------
interface fird_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [fird_pkg::SAMPLE_W-1:0] sample_in;
  logic        [fird_pkg::CIDX_W-1:0]   coef_index;
  logic signed [fird_pkg::COEF_W-1:0]   coef_value;

  modport source (output valid, command, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, command, sample_in, coef_index, coef_value, output ready);
endinterface

// ===== hdl/fird_out_if.sv =====
// ----------------------------------------------------------------------------
// fird_out_if
// Output channel: filtered, decimated samples with a clip flag.
// ----------------------------------------------------------------------------
interface fird_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fird_pkg::SAMPLE_W-1:0] sample_out;
  logic                                saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

// ===== hdl/fird_ctrl.sv =====
// ----------------------------------------------------------------------------
// fird_ctrl
// Sequencer: accepts words, walks the taps, drains the mac pipe, hands off.
// ----------------------------------------------------------------------------
module fird_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  fird_pkg::dp_status_t   status,
  output fird_pkg::ctrl_cmd_t    cmd,
  output logic                   in_ready
);

  fird_pkg::state_t state;
  fird_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fird_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fird_pkg::ST_IDLE: begin
        if (in_valid && status.fire) state_next = fird_pkg::ST_RUN;
      end
      fird_pkg::ST_RUN: begin
        if (status.tap_last) state_next = fird_pkg::ST_DRAIN;
      end
      fird_pkg::ST_DRAIN: begin
        if (!status.busy) state_next = fird_pkg::ST_FINISH;
      end
      fird_pkg::ST_FINISH: begin
        if (status.out_free) state_next = fird_pkg::ST_IDLE;
      end
      default: state_next = fird_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == fird_pkg::ST_IDLE);
    cmd.take  = in_ready && in_valid;
    cmd.start = cmd.take && status.fire;
    cmd.issue = (state == fird_pkg::ST_RUN);
    cmd.load  = (state == fird_pkg::ST_FINISH) && status.out_free;
  end

endmodule

// ===== hdl/fird_datapath.sv =====
// ----------------------------------------------------------------------------
// fird_datapath
// Registers, delay line and coefficient memories, shared mac, output stage.
// ----------------------------------------------------------------------------
module fird_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fird_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fird_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  command,
  input  logic signed [fird_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic [fird_pkg::CIDX_W-1:0]            coef_index,
  input  logic signed [fird_pkg::COEF_W-1:0]     coef_value,
  input  fird_pkg::ctrl_cmd_t                   cmd,
  output fird_pkg::dp_status_t                  status,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fird_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                                  saturated
);

  localparam int TAP_W   = fird_pkg::TAP_W;
  localparam int CNT_W   = fird_pkg::CNT_W;
  localparam int PHASE_W = fird_pkg::PHASE_W;
  localparam int DECIM_W = fird_pkg::DECIM_W;
  localparam int CMP_W   = DECIM_W + 1;
  localparam int ACC_W   = fird_pkg::ACC_W;
  localparam int SH_W    = ACC_W - fird_pkg::FRAC;

  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
  localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(32768);
  localparam logic signed [fird_pkg::SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [fird_pkg::SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

  // configuration registers
  logic [fird_pkg::DECREG_W-1:0]  decim_reg;
  logic [fird_pkg::TAPSREG_W-1:0] taps_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      decim_reg <= fird_pkg::DECIM_RESET;
      taps_reg  <= fird_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fird_pkg::REG_DECIMATION: decim_reg <= cfg_data[fird_pkg::DECREG_W-1:0];
        fird_pkg::REG_NUM_TAPS:   taps_reg  <= cfg_data[fird_pkg::TAPSREG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective tap count and decimation factor
  logic [CNT_W-1:0]   k_eff;
  logic [DECIM_W-1:0] r_eff;

  always_comb begin
    if (taps_reg == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(taps_reg) > 32'(fird_pkg::MAX_TAPS)) begin
      k_eff = CNT_W'(fird_pkg::MAX_TAPS);
    end else begin
      k_eff = CNT_W'(taps_reg);
    end
    if (decim_reg == '0) begin
      r_eff = DECIM_W'(1);
    end else if (32'(decim_reg) > 32'(fird_pkg::MAX_DECIMATION)) begin
      r_eff = DECIM_W'(fird_pkg::MAX_DECIMATION);
    end else begin
      r_eff = DECIM_W'(decim_reg);
    end
  end

  // write pointer and phase
  logic [TAP_W-1:0]   wp;
  logic [TAP_W-1:0]   wp_eff;
  logic [TAP_W-1:0]   wp_after;
  logic [CNT_W-1:0]   wp_inc;
  logic [PHASE_W-1:0] phase;
  logic               phase_done;
  logic               push;

  always_comb begin
    wp_eff     = (CNT_W'(wp) >= k_eff) ? '0 : wp;
    wp_inc     = CNT_W'(wp_eff) + CNT_W'(1);
    wp_after   = (wp_inc >= k_eff) ? '0 : wp_inc[TAP_W-1:0];
    phase_done = (CMP_W'(phase) + CMP_W'(1)) >= CMP_W'(r_eff);
    push       = cmd.take && (command == fird_pkg::CMD_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      phase <= '0;
    end else if (push) begin
      wp    <= wp_after;
      phase <= phase_done ? '0 : phase + PHASE_W'(1);
    end
  end

  // delay line: memory plus one valid bit per entry
  logic signed [fird_pkg::SAMPLE_W-1:0] delay_mem [fird_pkg::MAX_TAPS];
  logic [fird_pkg::MAX_TAPS-1:0]        delay_ok;

  always_ff @(posedge clk) begin
    if (push) delay_mem[wp_eff] <= sample_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ok <= '0;
    end else if (push) begin
      delay_ok[wp_eff] <= 1'b1;
    end
  end

  // coefficient memory, indexes past the store are dropped
  logic signed [fird_pkg::COEF_W-1:0] coef_mem [fird_pkg::MAX_TAPS];
  logic [31:0]                         cidx_wide;
  logic                                coef_wr;

  always_comb begin
    cidx_wide = 32'(coef_index);
    coef_wr   = cmd.take && (command == fird_pkg::CMD_COEF) &&
                (cidx_wide < 32'(fird_pkg::MAX_TAPS));
  end

  always_ff @(posedge clk) begin
    if (coef_wr) coef_mem[cidx_wide[TAP_W-1:0]] <= coef_value;
  end

  // tap walk: coefficient index and delay line position
  logic [TAP_W-1:0] tap;
  logic [TAP_W-1:0] pos;
  logic [CNT_W-1:0] pos_inc;

  always_comb begin
    pos_inc = CNT_W'(pos) + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tap <= '0;
      pos <= wp_after;
    end else if (cmd.issue) begin
      tap <= tap + TAP_W'(1);
      pos <= (pos_inc >= k_eff) ? '0 : pos_inc[TAP_W-1:0];
    end
  end

  // memory reads, registered
  logic signed [fird_pkg::COEF_W-1:0]   coef_rd;
  logic signed [fird_pkg::SAMPLE_W-1:0] delay_rd;
  logic                                 ok_rd;
  logic                                 rd_v;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      coef_rd  <= coef_mem[tap];
      delay_rd <= delay_mem[pos];
      ok_rd    <= delay_ok[pos];
    end
  end

  // multiply stage
  logic signed [fird_pkg::PROD_W-1:0]   prod;
  logic signed [fird_pkg::SAMPLE_W-1:0] mul_b;
  logic                                 prod_v;

  always_comb begin
    mul_b = ok_rd ? delay_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (rd_v) prod <= coef_rd * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.issue;
      prod_v <= rd_v;
    end
  end

  // accumulate
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor shift and clip
  logic signed [SH_W-1:0] shifted;
  logic                   clip_hi;
  logic                   clip_lo;

  always_comb begin
    shifted = $signed(acc[ACC_W-1:fird_pkg::FRAC]);
    clip_hi = shifted > SAT_HI;
    clip_lo = shifted < SAT_LO;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      priority if (clip_hi) begin
        sample_out <= OUT_MAX;
      end else if (clip_lo) begin
        sample_out <= OUT_MIN;
      end else begin
        sample_out <= shifted[fird_pkg::SAMPLE_W-1:0];
      end
      saturated <= clip_hi || clip_lo;
    end
  end

  // status to the sequencer
  always_comb begin
    status.fire     = (command == fird_pkg::CMD_PUSH) && phase_done;
    status.tap_last = (CNT_W'(tap) + CNT_W'(1)) == k_eff;
    status.busy     = rd_v || prod_v;
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== hdl/fir_decimator.sv =====
// ----------------------------------------------------------------------------
// fir_decimator: decimating fir filter, q1.15 in and out, one shared mac
// a coefficient load or a sample that ends no phase is only stored, with no result
// a sample that ends a phase walks the taps, one tap per cycle through the
// shared mac, then pipe drain, clip and hand-off; the result waits while
// the output register still holds a word
// rst (synchronous) clears delay line valid bits, pointer and phase; coefficients unset
// ----------------------------------------------------------------------------
module fir_decimator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fird_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fird_pkg::CFG_DATA_W-1:0] cfg_data,
  fird_in_if.sink                        feed,
  fird_out_if.source                     result
);

  fird_pkg::ctrl_cmd_t  cmd;
  fird_pkg::dp_status_t status;

  // sequencer
  fird_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .status   (status),
    .cmd      (cmd),
    .in_ready (feed.ready)
  );

  // datapath
  fird_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (feed.command),
    .sample_in  (feed.sample_in),
    .coef_index (feed.coef_index),
    .coef_value (feed.coef_value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .sample_out (result.sample_out),
    .saturated  (result.saturated)
  );

endmodule
